FILE: design/dpfr_pkg.sv
package dpfr_pkg;

    // Receiver phase codes
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_SUM_HI  = 2'd2;
    localparam logic [1:0] PH_SUM_LO  = 2'd3;

    // Event kinds on the result channel
    localparam logic [1:0] EV_START   = 2'd0;
    localparam logic [1:0] EV_BYTE    = 2'd1;
    localparam logic [1:0] EV_ACK     = 2'd2;
    localparam logic [1:0] EV_NAK     = 2'd3;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    // 'a' - 10
    localparam logic [7:0] CH_HEX_OFS = 8'h57;

    localparam int unsigned LEN_W     = 9;
    localparam logic [LEN_W-1:0] COUNT_CAP = 9'd511;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
    } result_t;

    // Lower-case-only hex decode; other bytes give whatever the subtraction yields
    function automatic logic [7:0] digit_value(input logic [7:0] b);
        logic [7:0] v;
        if (b <= CH_NINE) begin
            v = b - CH_ZERO;
        end else begin
            v = b - CH_HEX_OFS;
        end
        return v;
    endfunction

endpackage

FILE: design/debug_packet_frame_receiver_core.sv
// Debug packet frame receiver.
// Input channel (s_*): one received serial character per transfer on s_tdata.
// Result channel (m_*): zero or one event per input character. m_tuser holds
// the event kind (frame start, payload byte kept, checksum ack, checksum nak);
// m_tdata holds the character ('$', the payload byte, '+' or '-') and the
// number of payload bytes kept in the frame so far.
// Each event is registered (output or skid register) before it shows on m_*.
// Throughput: one character per cycle while s_tready is high; the state update
// is a single short compare/add between the input handshake and the output register.
// A two-entry output stage (output register plus skid register) keeps
// s_tready registered; when the sink stalls, one more event is absorbed by
// the skid register, then s_tready drops until the sink takes a transfer.
// Characters that produce no event never wait on the sink beyond that.
// Reset (aresetn low, synchronous) returns to hunting for '$', clears the
// count, sum and digit state, and empties the output stage.
// Bytes beyond PAYLOAD_MAX (capped at 511) in one frame are dropped silently.
module debug_packet_frame_receiver_core #(
    parameter int unsigned PAYLOAD_MAX = 511
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [16:8] payload_length, [23:17] zero
    output logic [1:0]  m_tuser    // [1:0] event_kind
);

    localparam int unsigned LEN_W = dpfr_pkg::LEN_W;
    localparam logic [LEN_W-1:0] KEEP_CAP =
        (PAYLOAD_MAX < 511) ? LEN_W'(PAYLOAD_MAX) : dpfr_pkg::COUNT_CAP;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [7:0]       hi_digit_reg, hi_digit_next;

    logic               out_valid_reg;
    dpfr_pkg::result_t  out_reg;
    logic               skid_valid_reg;
    dpfr_pkg::result_t  skid_reg;

    logic               accept;
    logic               out_take;
    logic               res_valid;
    dpfr_pkg::result_t  res;
    logic [7:0]         rx_digit;
    logic [7:0]         rx_sum;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.len, out_reg.data};

    always_comb begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        hi_digit_next = hi_digit_reg;
        res_valid     = 1'b0;
        res.kind      = dpfr_pkg::EV_START;
        res.data      = s_tdata;
        res.len       = count_reg;
        rx_digit      = dpfr_pkg::digit_value(s_tdata);
        rx_sum        = hi_digit_reg | rx_digit;
        unique case (phase_reg)
            dpfr_pkg::PH_HUNT: begin
                if (s_tdata == dpfr_pkg::CH_DOLLAR) begin
                    sum_next   = 8'd0;
                    count_next = '0;
                    phase_next = dpfr_pkg::PH_PAYLOAD;
                    res_valid  = 1'b1;
                    res.kind   = dpfr_pkg::EV_START;
                    res.data   = dpfr_pkg::CH_DOLLAR;
                    res.len    = '0;
                end
            end
            dpfr_pkg::PH_PAYLOAD: begin
                if (s_tdata == dpfr_pkg::CH_HASH) begin
                    phase_next = dpfr_pkg::PH_SUM_HI;
                end else if (count_reg < KEEP_CAP) begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + s_tdata;
                    res_valid  = 1'b1;
                    res.kind   = dpfr_pkg::EV_BYTE;
                    res.data   = s_tdata;
                    res.len    = count_reg + 1'b1;
                end
            end
            dpfr_pkg::PH_SUM_HI: begin
                hi_digit_next = {rx_digit[3:0], 4'd0};
                phase_next    = dpfr_pkg::PH_SUM_LO;
            end
            dpfr_pkg::PH_SUM_LO: begin
                phase_next = dpfr_pkg::PH_HUNT;
                res_valid  = 1'b1;
                if (rx_sum == sum_reg) begin
                    res.kind = dpfr_pkg::EV_ACK;
                    res.data = dpfr_pkg::CH_PLUS;
                end else begin
                    res.kind = dpfr_pkg::EV_NAK;
                    res.data = dpfr_pkg::CH_MINUS;
                end
            end
            default: begin
                phase_next = dpfr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= dpfr_pkg::PH_HUNT;
            sum_reg      <= 8'd0;
            count_reg    <= '0;
            hi_digit_reg <= 8'd0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            hi_digit_reg <= hi_digit_next;
        end
    end

    // Output register plus skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_reg <= skid_reg;
            end
        end else if (accept && res_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an event while output register is empty");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= KEEP_CAP)
        else $error("kept count above capacity");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == dpfr_pkg::PH_HUNT && s_tdata == dpfr_pkg::CH_DOLLAR
        |=> phase_reg == dpfr_pkg::PH_PAYLOAD && count_reg == '0 && sum_reg == 8'd0)
        else $error("frame start did not clear count and sum");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == dpfr_pkg::PH_PAYLOAD && s_tdata != dpfr_pkg::CH_HASH
        && count_reg < KEEP_CAP
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("kept count did not advance on a kept byte");
`endif

endmodule
